[sv/assert_macros.svh]
// Assertion macros shared by the RTL files of the JPEG header probe.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define JHP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define JHP_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define JHP_ASSERT(label, clk, rst_n, prop, msg)

`define JHP_ASSERT_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

[sv/jhp_pkg.sv]
// Types and constants shared by the JPEG header probe modules.
`default_nettype none

package jhp_pkg;

    localparam int unsigned WINDOW_BITS = 17;
    localparam int unsigned SKIP_BITS   = 17;
    localparam int unsigned RES_BITS    = 80;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_SCAN_WINDOW = 2'd0;
    localparam logic [1:0] REG_MIN_DIM     = 2'd1;
    localparam logic [1:0] REG_ALIGN_LOG2  = 2'd2;

    localparam logic [16:0] SCAN_WINDOW_RST = 17'd65536;
    localparam logic [15:0] MIN_DIM_RST     = 16'd64;
    localparam logic [3:0]  ALIGN_LOG2_RST  = 4'd4;

    // Parse phases.
    localparam logic [3:0] PH_SOI0  = 4'd0;
    localparam logic [3:0] PH_SOI1  = 4'd1;
    localparam logic [3:0] PH_SEEK  = 4'd2;
    localparam logic [3:0] PH_MARK  = 4'd3;
    localparam logic [3:0] PH_LENHI = 4'd4;
    localparam logic [3:0] PH_LENLO = 4'd5;
    localparam logic [3:0] PH_SKIP  = 4'd6;
    localparam logic [3:0] PH_SOF   = 4'd7;
    localparam logic [3:0] PH_DONE  = 4'd8;

    // Marker codes.
    localparam logic [7:0] MK_PREFIX = 8'hFF;
    localparam logic [7:0] MK_SOI    = 8'hD8;
    localparam logic [7:0] MK_EOI    = 8'hD9;
    localparam logic [7:0] MK_RST0   = 8'hD0;
    localparam logic [7:0] MK_RST7   = 8'hD7;
    localparam logic [7:0] MK_TEM    = 8'h01;
    localparam logic [7:0] MK_SOF0   = 8'hC0;
    localparam logic [7:0] MK_SOF15  = 8'hCF;
    localparam logic [7:0] MK_DHT    = 8'hC4;
    localparam logic [7:0] MK_JPG    = 8'hC8;
    localparam logic [7:0] MK_DAC    = 8'hCC;
    localparam logic [7:0] MK_SOS    = 8'hDA;

    localparam logic [SKIP_BITS-1:0] SOF_FIELD_BYTES = 17'd6;

    typedef struct packed {
        logic [16:0] scan_window;
        logic [15:0] min_hw_dimension;
        logic [3:0]  hw_align_log2;
    } cfg_t;

    typedef struct packed {
        logic [31:0] byte_count;
        logic [7:0]  component_count;
        logic [15:0] image_height;
        logic [15:0] image_width;
        logic        hw_decode_ok;
        logic        has_end;
        logic        has_frame_header;
        logic        has_start;
        logic        image_valid;
    } res_t;

endpackage

`default_nettype wire

[sv/jhp_core.sv]
// Per-byte marker walker, SOF capture and result formation.
`default_nettype none
`include "assert_macros.svh"

module jhp_core #(
    parameter int unsigned COUNT_BITS = 32
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire jhp_pkg::cfg_t cfg,
    input  wire logic         go,
    input  wire logic [7:0]   data_byte,
    input  wire logic         last_byte,
    output jhp_pkg::res_t     res
);

    logic [COUNT_BITS-1:0]         idx_reg, idx_next;
    logic [7:0]                    prev_reg, prev_next;
    logic [3:0]                    phase_reg, phase_next;
    logic [7:0]                    marker_reg, marker_next;
    logic [jhp_pkg::SKIP_BITS-1:0] skip_reg, skip_next, skip_dec;
    logic [15:0]                   seg_reg, seg_next;
    logic                          start_reg, start_next;
    logic                          frame_reg, frame_next;
    logic [15:0]                   width_reg, width_next;
    logic [15:0]                   height_reg, height_next;
    logic [7:0]                    comp_reg, comp_next;

    logic                  in_window;
    logic                  is_frame;
    logic                  end_ok;
    logic [15:0]           amask;
    logic [COUNT_BITS-1:0] count;
    logic [15:0]           w_out, h_out;

    always_comb
    begin
        in_window = idx_reg < COUNT_BITS'(cfg.scan_window);
        is_frame  = (marker_reg inside {[jhp_pkg::MK_SOF0:jhp_pkg::MK_SOF15]}) &&
                    !(marker_reg inside {jhp_pkg::MK_DHT, jhp_pkg::MK_JPG, jhp_pkg::MK_DAC});
        skip_dec  = skip_reg - jhp_pkg::SKIP_BITS'(1);

        phase_next  = phase_reg;
        marker_next = marker_reg;
        skip_next   = skip_reg;
        seg_next    = seg_reg;
        start_next  = start_reg;
        frame_next  = frame_reg;
        width_next  = width_reg;
        height_next = height_reg;
        comp_next   = comp_reg;

        if (in_window)
        begin
            case (phase_reg)
                jhp_pkg::PH_SOI0:
                begin
                    phase_next = (data_byte == jhp_pkg::MK_PREFIX) ? jhp_pkg::PH_SOI1
                                                                   : jhp_pkg::PH_DONE;
                end
                jhp_pkg::PH_SOI1:
                begin
                    if (data_byte == jhp_pkg::MK_SOI)
                    begin
                        start_next = 1'b1;
                        phase_next = jhp_pkg::PH_SEEK;
                    end
                    else
                    begin
                        phase_next = jhp_pkg::PH_DONE;
                    end
                end
                jhp_pkg::PH_SEEK:
                begin
                    if (data_byte == jhp_pkg::MK_PREFIX)
                    begin
                        phase_next = jhp_pkg::PH_MARK;
                    end
                end
                jhp_pkg::PH_MARK:
                begin
                    if (data_byte == jhp_pkg::MK_PREFIX)
                    begin
                        phase_next = jhp_pkg::PH_MARK;
                    end
                    else if ((data_byte inside {[jhp_pkg::MK_RST0:jhp_pkg::MK_EOI]}) ||
                             data_byte == jhp_pkg::MK_TEM)
                    begin
                        phase_next = jhp_pkg::PH_SEEK;
                    end
                    else
                    begin
                        marker_next = data_byte;
                        phase_next  = jhp_pkg::PH_LENHI;
                    end
                end
                jhp_pkg::PH_LENHI:
                begin
                    seg_next   = {data_byte, 8'h00};
                    phase_next = jhp_pkg::PH_LENLO;
                end
                jhp_pkg::PH_LENLO:
                begin
                    seg_next = {seg_reg[15:8], data_byte};
                    if (is_frame)
                    begin
                        skip_next  = jhp_pkg::SOF_FIELD_BYTES;
                        phase_next = jhp_pkg::PH_SOF;
                    end
                    else if (marker_reg == jhp_pkg::MK_SOS || seg_next < 16'd2)
                    begin
                        phase_next = jhp_pkg::PH_DONE;
                    end
                    else if (seg_next == 16'd2)
                    begin
                        phase_next = jhp_pkg::PH_SEEK;
                    end
                    else
                    begin
                        skip_next  = jhp_pkg::SKIP_BITS'(seg_next) - 17'd2;
                        phase_next = jhp_pkg::PH_SKIP;
                    end
                end
                jhp_pkg::PH_SKIP:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == '0)
                    begin
                        phase_next = jhp_pkg::PH_SEEK;
                    end
                end
                jhp_pkg::PH_SOF:
                begin
                    case (skip_reg)
                        17'd5:   height_next = {data_byte, 8'h00};
                        17'd4:   height_next = {height_reg[15:8], data_byte};
                        17'd3:   width_next  = {data_byte, 8'h00};
                        17'd2:   width_next  = {width_reg[15:8], data_byte};
                        17'd1:   comp_next   = data_byte;
                        default: ;
                    endcase
                    skip_next = skip_dec;
                    if (skip_dec == '0)
                    begin
                        frame_next = 1'b1;
                        phase_next = jhp_pkg::PH_DONE;
                    end
                end
                default:
                begin
                    phase_next = jhp_pkg::PH_DONE;
                end
            endcase
        end

        end_ok    = (prev_reg == jhp_pkg::MK_PREFIX) && (data_byte == jhp_pkg::MK_EOI);
        idx_next  = (idx_reg == '1) ? idx_reg : idx_reg + COUNT_BITS'(1);
        prev_next = data_byte;
        count     = idx_next;

        // Result from the state after this byte.
        w_out = frame_next ? width_next : 16'd0;
        h_out = frame_next ? height_next : 16'd0;
        amask = 16'((17'd1 << cfg.hw_align_log2) - 17'd1);
        res   = '0;
        if (count >= COUNT_BITS'(4))
        begin
            res.image_valid      = start_next && frame_next && end_ok &&
                                   (w_out != 16'd0) && (h_out != 16'd0);
            res.has_start        = start_next;
            res.has_frame_header = frame_next;
            res.has_end          = end_ok;
            res.hw_decode_ok     = frame_next && ((w_out & amask) == 16'd0) &&
                                   ((h_out & amask) == 16'd0) &&
                                   (w_out >= cfg.min_hw_dimension) &&
                                   (h_out >= cfg.min_hw_dimension);
            res.image_width      = w_out;
            res.image_height     = h_out;
            res.component_count  = frame_next ? comp_next : 8'd0;
            res.byte_count       = (count > COUNT_BITS'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
                                                                       : 32'(count);
        end

        // The last byte of a file rearms the walker.
        if (last_byte)
        begin
            idx_next    = '0;
            prev_next   = 8'd0;
            phase_next  = jhp_pkg::PH_SOI0;
            marker_next = 8'd0;
            skip_next   = '0;
            seg_next    = 16'd0;
            start_next  = 1'b0;
            frame_next  = 1'b0;
            width_next  = 16'd0;
            height_next = 16'd0;
            comp_next   = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            prev_reg   <= 8'd0;
            phase_reg  <= jhp_pkg::PH_SOI0;
            marker_reg <= 8'd0;
            skip_reg   <= '0;
            seg_reg    <= 16'd0;
            start_reg  <= 1'b0;
            frame_reg  <= 1'b0;
            width_reg  <= 16'd0;
            height_reg <= 16'd0;
            comp_reg   <= 8'd0;
        end
        else if (go)
        begin
            idx_reg    <= idx_next;
            prev_reg   <= prev_next;
            phase_reg  <= phase_next;
            marker_reg <= marker_next;
            skip_reg   <= skip_next;
            seg_reg    <= seg_next;
            start_reg  <= start_next;
            frame_reg  <= frame_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            comp_reg   <= comp_next;
        end
    end

    `JHP_ASSERT(a_frame, clk, rst_n, frame_reg |-> phase_reg == jhp_pkg::PH_DONE, "walk after SOF")
    `JHP_ASSERT(a_start, clk, rst_n, start_reg |-> phase_reg > jhp_pkg::PH_SOI1, "start too early")
    `JHP_ASSERT(a_skip, clk, rst_n, phase_reg == jhp_pkg::PH_SKIP |-> skip_reg != '0, "empty skip")
    `JHP_ASSERT(a_sof, clk, rst_n, phase_reg == jhp_pkg::PH_SOF |-> skip_reg != '0, "empty SOF count")

endmodule

`default_nettype wire

[sv/jpeg_header_probe_top.sv]
// Top level of the JPEG header probe: register port, input stage and result register.
`default_nettype none
`include "assert_macros.svh"

// The probe takes one file byte per cycle unless input is held. The result item for a
// file is loaded into the result register and presented on the master side when its
// final byte, held in the input stage register, is parsed by the core. Each byte is
// parsed by a single registered pass over a small marker walker, so the sustained rate
// is one item per clock; input is held only while a finished result waits to be taken
// and the next final byte would need the result register.

module jpeg_header_probe_top #(
    parameter int unsigned COUNT_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // APB-style configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // Byte stream in
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // data_byte
    input  wire logic        s_axis_tlast,   // last_byte
    // Result out
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // image_valid, has_start, has_frame_header, has_end, hw_decode_ok,
    // image_width, image_height, component_count, byte_count, zero pad
    output logic [79:0]      m_axis_tdata
);

    jhp_pkg::cfg_t cfg_reg;
    logic          cfg_wr;
    logic [1:0]    cfg_idx;

    logic          s1_valid_reg;
    logic [7:0]    s1_byte_reg;
    logic          s1_last_reg;
    logic          s1_go;
    logic          take_last;
    logic          out_free;

    jhp_pkg::res_t res;
    jhp_pkg::res_t out_reg;
    logic          out_valid_reg;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scan_window      <= jhp_pkg::SCAN_WINDOW_RST;
            cfg_reg.min_hw_dimension <= jhp_pkg::MIN_DIM_RST;
            cfg_reg.hw_align_log2    <= jhp_pkg::ALIGN_LOG2_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                jhp_pkg::REG_SCAN_WINDOW: cfg_reg.scan_window      <= pwdata[16:0];
                jhp_pkg::REG_MIN_DIM:     cfg_reg.min_hw_dimension <= pwdata[15:0];
                jhp_pkg::REG_ALIGN_LOG2:  cfg_reg.hw_align_log2    <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            jhp_pkg::REG_SCAN_WINDOW: prdata = 32'(cfg_reg.scan_window);
            jhp_pkg::REG_MIN_DIM:     prdata = 32'(cfg_reg.min_hw_dimension);
            jhp_pkg::REG_ALIGN_LOG2:  prdata = 32'(cfg_reg.hw_align_log2);
            default:                  prdata = 32'd0;
        endcase
    end

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s1_go         = s1_valid_reg && (!s1_last_reg || out_free);
    assign take_last     = s1_go && s1_last_reg;
    assign s_axis_tready = !s1_valid_reg || s1_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            s1_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            s1_byte_reg <= s_axis_tdata;
            s1_last_reg <= s_axis_tlast;
        end
    end

    jhp_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .go        (s1_go),
        .data_byte (s1_byte_reg),
        .last_byte (s1_last_reg),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take_last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_last)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_reg};

    `JHP_ASSERT(a_from_last, clk, rst_n, $rose(out_valid_reg) |-> $past(take_last), "stray result")
    `JHP_ASSERT_NEVER(a_no_overwrite, clk, rst_n, take_last && !out_free, "result overwritten")
    `JHP_ASSERT(a_held, clk, rst_n, !out_free |=> out_valid_reg && $stable(out_reg), "result moved")

endmodule

`default_nettype wire

[dv/tb_jpeg_header_probe_top.sv]
// Self-checking testbench for the JPEG header probe: byte stream in, header result out.
`default_nettype none

module tb_jpeg_header_probe_top;
    import jhp_pkg::*;

    localparam logic [7:0] MK_APP0 = 8'hE0;
    localparam logic [7:0] MK_DQT  = 8'hDB;
    localparam logic [7:0] MK_COM  = 8'hFE;
    localparam longint unsigned COUNT_SAT = 64'hFFFF_FFFF;

    // Smallest complete file: SOI, a 64 by 64 SOF with three components, EOI.
    localparam logic [255:0] MIN_JPEG = 112'hFFD8_FFC0_0011_0800_4000_4003_FFD9;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } byte_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;

    byte_item_t  stream_q[$];
    res_t        header_results_q[$];
    logic [7:0]  file_buf[$];

    int          send_idle_pct = 33;
    int          recv_idle_pct = 61;
    bit          stall_request = 1'b0;
    int          stall_left = 0;
    int          errors = 0;
    int          bytes_loaded = 0;
    int          bytes_accepted = 0;
    int          results_checked = 0;
    int          settings_used = 0;

    // Register copies and parser state of the predictor.
    logic [16:0]     cfg_window = SCAN_WINDOW_RST;
    logic [15:0]     cfg_min_dim = MIN_DIM_RST;
    logic [3:0]      cfg_align = ALIGN_LOG2_RST;
    longint unsigned hp_count;
    logic [7:0]      hp_prev;
    logic [3:0]      hp_phase;
    logic [7:0]      hp_marker;
    logic [16:0]     hp_skip;
    logic [15:0]     hp_seglen;
    logic            hp_start;
    logic            hp_frame;
    logic [15:0]     hp_w;
    logic [15:0]     hp_h;
    logic [7:0]      hp_c;

    jpeg_header_probe_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic clear_probe();
        hp_count  = 0;
        hp_prev   = '0;
        hp_phase  = PH_SOI0;
        hp_marker = '0;
        hp_skip   = '0;
        hp_seglen = '0;
        hp_start  = 1'b0;
        hp_frame  = 1'b0;
        hp_w      = '0;
        hp_h      = '0;
        hp_c      = '0;
    endtask

    // Advances the header walk by one accepted byte and queues the result on a final byte.
    task automatic probe_byte(input logic [7:0] b, input logic last);
        res_t        r;
        logic        end_ok;
        logic        is_sof;
        logic [31:0] amask;
        if (hp_count < longint'(cfg_window))
        begin
            is_sof = hp_marker >= MK_SOF0 && hp_marker <= MK_SOF15 && hp_marker != MK_DHT
                     && hp_marker != MK_JPG && hp_marker != MK_DAC;
            case (hp_phase)
                PH_SOI0: hp_phase = (b == MK_PREFIX) ? PH_SOI1 : PH_DONE;
                PH_SOI1:
                begin
                    if (b == MK_SOI)
                    begin
                        hp_start = 1'b1;
                        hp_phase = PH_SEEK;
                    end
                    else
                        hp_phase = PH_DONE;
                end
                PH_SEEK: if (b == MK_PREFIX) hp_phase = PH_MARK;
                PH_MARK:
                begin
                    if (b != MK_PREFIX)
                    begin
                        if (b == MK_SOI || b == MK_EOI || (b >= MK_RST0 && b <= MK_RST7)
                            || b == MK_TEM)
                            hp_phase = PH_SEEK;
                        else
                        begin
                            hp_marker = b;
                            hp_phase = PH_LENHI;
                        end
                    end
                end
                PH_LENHI:
                begin
                    hp_seglen = {b, 8'h00};
                    hp_phase = PH_LENLO;
                end
                PH_LENLO:
                begin
                    hp_seglen[7:0] = b;
                    if (is_sof)
                    begin
                        hp_skip = SOF_FIELD_BYTES;
                        hp_phase = PH_SOF;
                    end
                    else if (hp_marker == MK_SOS || hp_seglen < 16'd2)
                        hp_phase = PH_DONE;
                    else if (hp_seglen == 16'd2)
                        hp_phase = PH_SEEK;
                    else
                    begin
                        hp_skip = {1'b0, hp_seglen} - 17'd2;
                        hp_phase = PH_SKIP;
                    end
                end
                PH_SKIP:
                begin
                    hp_skip = hp_skip - 17'd1;
                    if (hp_skip == '0) hp_phase = PH_SEEK;
                end
                PH_SOF:
                begin
                    case (hp_skip)
                        17'd5: hp_h = {b, 8'h00};
                        17'd4: hp_h[7:0] = b;
                        17'd3: hp_w = {b, 8'h00};
                        17'd2: hp_w[7:0] = b;
                        17'd1: hp_c = b;
                        default: ;
                    endcase
                    hp_skip = hp_skip - 17'd1;
                    if (hp_skip == '0)
                    begin
                        hp_frame = 1'b1;
                        hp_phase = PH_DONE;
                    end
                end
                default: hp_phase = PH_DONE;
            endcase
        end
        end_ok = (hp_prev == MK_PREFIX) && (b == MK_EOI);
        if (hp_count < COUNT_SAT) hp_count++;
        hp_prev = b;
        if (last)
        begin
            r = '0;
            if (hp_count >= 4)
            begin
                r.image_width      = hp_frame ? hp_w : 16'd0;
                r.image_height     = hp_frame ? hp_h : 16'd0;
                r.component_count  = hp_frame ? hp_c : 8'd0;
                amask = (32'd1 << cfg_align) - 32'd1;
                r.hw_decode_ok     = hp_frame && (({16'd0, r.image_width} & amask) == 0)
                                     && (({16'd0, r.image_height} & amask) == 0)
                                     && r.image_width >= cfg_min_dim
                                     && r.image_height >= cfg_min_dim;
                r.image_valid      = hp_start && hp_frame && end_ok
                                     && r.image_width != 0 && r.image_height != 0;
                r.has_start        = hp_start;
                r.has_frame_header = hp_frame;
                r.has_end          = end_ok;
                r.byte_count       = hp_count[31:0];
            end
            header_results_q.push_back(r);
            clear_probe();
        end
    endtask

    always @(posedge clk)
    begin : drive_proc
        byte_item_t nxt;
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                probe_byte(s_axis_tdata, s_axis_tlast);
                bytes_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (stream_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = stream_q.pop_front();
                    s_axis_tdata  <= nxt.data;
                    s_axis_tlast  <= nxt.last;
                    s_axis_tvalid <= 1'b1;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : ready_proc
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (stall_request)
        begin
            stall_request = 1'b0;
            stall_left = 400;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin : monitor_proc
        res_t got;
        res_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[76:0];
            if (header_results_q.size() == 0)
            begin
                $error("result item arrived with none expected");
                errors++;
            end
            else
            begin
                want = header_results_q.pop_front();
                check_field("image_valid", want.image_valid, got.image_valid);
                check_field("has_start", want.has_start, got.has_start);
                check_field("has_frame_header", want.has_frame_header, got.has_frame_header);
                check_field("has_end", want.has_end, got.has_end);
                check_field("hw_decode_ok", want.hw_decode_ok, got.hw_decode_ok);
                check_field("image_width", want.image_width, got.image_width);
                check_field("image_height", want.image_height, got.image_height);
                check_field("component_count", want.component_count, got.component_count);
                check_field("byte_count", want.byte_count, got.byte_count);
                check_field("zero pad", 32'd0, {29'd0, m_axis_tdata[79:77]});
            end
            results_checked++;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SCAN_WINDOW: cfg_window  = val[16:0];
            REG_MIN_DIM:     cfg_min_dim = val[15:0];
            REG_ALIGN_LOG2:  cfg_align   = val[3:0];
            default: ;
        endcase
        settings_used++;
    endtask

    task automatic set_probe_config(input logic [16:0] window, input logic [15:0] min_dim,
                                    input logic [3:0] align);
        write_reg(REG_SCAN_WINDOW, {15'd0, window});
        write_reg(REG_MIN_DIM, {16'd0, min_dim});
        write_reg(REG_ALIGN_LOG2, {28'd0, align});
    endtask

    // Holds the sender until every byte is taken and every result has been checked.
    task automatic wait_idle();
        while (stream_q.size() != 0 || s_axis_tvalid || header_results_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic flush_file();
        byte_item_t it;
        for (int i = 0; i < file_buf.size(); i++)
        begin
            it.data = file_buf[i];
            it.last = (i == file_buf.size() - 1);
            stream_q.push_back(it);
        end
        bytes_loaded += file_buf.size();
        file_buf.delete();
    endtask

    // Loads a whole file given as a hex vector, first byte in the highest used position.
    task automatic load_hex(input int n, input logic [255:0] v);
        for (int i = 0; i < n; i++)
            file_buf.push_back(v[8*(n-1-i) +: 8]);
        flush_file();
    endtask

    task automatic put_marker_segment(input logic [7:0] mk, input int len);
        file_buf.push_back(MK_PREFIX);
        file_buf.push_back(mk);
        file_buf.push_back(len[15:8]);
        file_buf.push_back(len[7:0]);
        repeat (len - 2) file_buf.push_back(8'($urandom));
    endtask

    function automatic logic [15:0] rand_dim();
        case ($urandom_range(5))
            0, 1: return 16'(16 * $urandom_range(1, 128));
            2: return 16'(256 * $urandom_range(0, 255));
            3: return 16'($urandom);
            4: return 16'($urandom_range(0, 127));
            default: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
        endcase
    endfunction

    task automatic put_filler();
        logic [7:0] mk;
        case ($urandom_range(4))
            0, 1:
            begin
                repeat ($urandom_range(0, 2)) file_buf.push_back(MK_PREFIX);
                file_buf.push_back(MK_PREFIX);
                case ($urandom_range(3))
                    0: mk = MK_RST0 + 8'($urandom_range(7));
                    1: mk = MK_SOI;
                    2: mk = MK_EOI;
                    default: mk = MK_TEM;
                endcase
                file_buf.push_back(mk);
            end
            default:
            begin
                case ($urandom_range(5))
                    0: mk = MK_APP0 + 8'($urandom_range(15));
                    1: mk = MK_DHT;
                    2: mk = $urandom_range(1) ? MK_JPG : MK_DAC;
                    3: mk = MK_DQT;
                    4: mk = MK_COM;
                    default: mk = 8'($urandom);
                endcase
                put_marker_segment(mk, $urandom_range(2, 8));
            end
        endcase
    endtask

    task automatic put_frame_header();
        logic [7:0]  mk;
        logic [15:0] len;
        logic [15:0] h;
        logic [15:0] w;
        do
            mk = MK_SOF0 + 8'($urandom_range(15));
        while (mk == MK_DHT || mk == MK_JPG || mk == MK_DAC);
        len = ($urandom_range(3) == 0) ? 16'($urandom) : 16'd17;
        h = rand_dim();
        w = ($urandom_range(2) == 0) ? rand_dim() : h;
        file_buf.push_back(MK_PREFIX);
        file_buf.push_back(mk);
        file_buf.push_back(len[15:8]);
        file_buf.push_back(len[7:0]);
        file_buf.push_back($urandom_range(1) ? 8'd8 : 8'($urandom));
        file_buf.push_back(h[15:8]);
        file_buf.push_back(h[7:0]);
        file_buf.push_back(w[15:8]);
        file_buf.push_back(w[7:0]);
        file_buf.push_back($urandom_range(3) ? 8'($urandom_range(1, 4)) : 8'($urandom));
    endtask

    task automatic gen_random_file();
        int kind;
        int keep;
        kind = $urandom_range(99);
        if (kind < 15)
        begin
            if ($urandom_range(1))
            begin
                file_buf.push_back(MK_PREFIX);
                file_buf.push_back(MK_SOI);
            end
            repeat ($urandom_range(1, 24)) file_buf.push_back(8'($urandom));
        end
        else
        begin
            file_buf.push_back(MK_PREFIX);
            file_buf.push_back(MK_SOI);
            repeat ($urandom_range(0, 3)) put_filler();
            case ($urandom_range(9))
                0: put_marker_segment(MK_SOS, $urandom_range(2, 6));
                1:
                begin
                    file_buf.push_back(MK_PREFIX);
                    file_buf.push_back(MK_APP0 + 8'($urandom_range(15)));
                    file_buf.push_back(8'd0);
                    file_buf.push_back(8'($urandom_range(1)));
                end
                default: ;
            endcase
            if ($urandom_range(9) != 0) put_frame_header();
            if ($urandom_range(1)) put_filler();
            repeat ($urandom_range(0, 6)) file_buf.push_back(8'($urandom));
            if ($urandom_range(9) < 8)
            begin
                file_buf.push_back(MK_PREFIX);
                file_buf.push_back(MK_EOI);
            end
            if (kind < 30)
            begin
                keep = $urandom_range(1, file_buf.size());
                while (file_buf.size() > keep) void'(file_buf.pop_back());
            end
        end
        flush_file();
    endtask

    initial
    begin : timeout_proc
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin : stim_proc
        int target;
        clear_probe();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Short files, no SOI, fill bytes, standalone markers and all-ones SOF fields.
        load_hex(1, 8'hFF);
        load_hex(3, 24'hFFD8FF);
        load_hex(4, 32'h0000_0000);
        load_hex(14, MIN_JPEG);
        load_hex(18, 144'hFFD8_FFFF_D0FF_01FF_C2FF_FFFF_FFFF_FFFF_FFD9);
        // Zero-length segment skip, EOI as standalone, SOF with a length field of 0.
        load_hex(26, 208'hFFD8_FFE0_0002_FFE1_0004_ABCD_FFD9_FFC1_0000_0800_1000_2001_FFD9);
        // SOS before SOF, then a segment length below 2.
        load_hex(18, 144'hFFD8_FFDA_0008_FFC0_0011_0800_4000_4003_FFD9);
        load_hex(18, 144'hFFD8_FFE0_0001_FFC0_0011_0800_4000_4003_FFD9);
        // SOF cut off by the end of the file, zero dimensions, missing EOI.
        load_hex(9, 72'hFFD8_FFC0_0011_0800_40);
        load_hex(14, 112'hFFD8_FFC0_0011_0800_0000_0003_FFD9);
        load_hex(14, 112'hFFD8_FFC0_0011_0800_4000_4003_0000);
        wait_idle();
        // SOF running past the window, then ending exactly at its edge.
        write_reg(REG_SCAN_WINDOW, 32'd10);
        load_hex(14, MIN_JPEG);
        wait_idle();
        write_reg(REG_SCAN_WINDOW, 32'd12);
        load_hex(14, MIN_JPEG);
        wait_idle();
        write_reg(REG_SCAN_WINDOW, 32'd1);
        load_hex(14, MIN_JPEG);
        wait_idle();
        write_reg(REG_SCAN_WINDOW, 32'd0);
        load_hex(14, MIN_JPEG);
        wait_idle();
        set_probe_config(17'd65536, 16'd0, 4'd0);
        load_hex(14, 112'hFFD8_FFC0_0011_0800_0000_0003_FFD9);
        wait_idle();
        set_probe_config(17'h1FFFF, 16'hFFFF, 4'd15);
        load_hex(18, 144'hFFD8_FFFF_D0FF_01FF_C2FF_FFFF_FFFF_FFFF_FFD9);
        wait_idle();
        set_probe_config(17'd65536, 16'd256, 4'd8);
        load_hex(14, 112'hFFD8_FFC0_0011_0801_0001_0003_FFD9);

        for (int ph = 0; ph < 6; ph++)
        begin
            wait_idle();
            case (ph)
                0: set_probe_config(SCAN_WINDOW_RST, MIN_DIM_RST, ALIGN_LOG2_RST);
                1: set_probe_config(17'h1FFFF, 16'd0, 4'd0);
                2: set_probe_config(17'($urandom_range(8, 80)), 16'($urandom_range(0, 300)),
                                    4'($urandom_range(0, 8)));
                3: set_probe_config(17'd65536, 16'hFFFF, 4'd15);
                4: set_probe_config(17'($urandom_range(1, 200)), 16'($urandom),
                                    4'($urandom_range(0, 15)));
                default: set_probe_config(17'd65536, 16'd16, 4'd8);
            endcase
            send_idle_pct = (ph < 2) ? 33 : (ph < 4) ? 61 : 0;
            recv_idle_pct = (ph < 2) ? 61 : (ph < 4) ? 33 : 0;
            if (ph == 5)
            begin
                // Many short files against a long receiver hold-off fill the block.
                repeat (12)
                begin
                    repeat ($urandom_range(4, 6)) file_buf.push_back(8'($urandom));
                    flush_file();
                end
                stall_request = 1'b1;
            end
            target = bytes_loaded + 120;
            while (bytes_loaded < target)
            begin
                gen_random_file();
                if (ph == 2 && bytes_loaded >= target - 60 && bytes_loaded < target - 30)
                    wait_idle();
            end
        end

        wait_idle();
        repeat (8) @(posedge clk);
        $display("Run covered %0d input items, %0d result items, %0d register writes.",
                 bytes_accepted, results_checked, settings_used);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
